// ===== src/bsim_pkg.sv =====
`timescale 1ns / 1ps
// types and constants shared by the bank switch irq mapper
package bsim_pkg;

  localparam int PATTERN_SLOTS = 8;
  localparam int SLOT_W        = $clog2(PATTERN_SLOTS);
  localparam int MAP_ADDR_W    = 22;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 8;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_CPU   = 2'd2,
    OP_PPU   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MIRROR_VERTICAL   = 2'd0,
    MIRROR_HORIZONTAL = 2'd1,
    MIRROR_SINGLE_0   = 2'd2,
    MIRROR_SINGLE_1   = 2'd3
  } mirror_t;

  // bus register selects, address bits 3..0
  localparam logic [3:0] REG_PRG_BANK = 4'h8;
  localparam logic [3:0] REG_MIRROR   = 4'h9;
  localparam logic [3:0] REG_IRQ_CTRL = 4'hA;
  localparam logic [3:0] REG_RELOAD_L = 4'hB;
  localparam logic [3:0] REG_RELOAD_H = 4'hC;
  localparam logic [3:0] REG_WRAM_EN  = 4'hD;

  // configuration port indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_AND   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_OR    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHR_AND   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHR_OR    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_WRAM_ALWS = 3'd4;

  localparam int WRAM_EN_BIT = 5;

  typedef struct packed {
    op_t         op;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic                  irq_active;
    logic [MAP_ADDR_W-1:0] mapped_address;
    logic                  mapped_valid;
  } rsp_t;

endpackage

// ===== src/bank_switch_irq_mapper_unit.sv =====
`timescale 1ns / 1ps
// bank switch irq mapper: register file, cycle counter and address translation
// an accepted request's result is in the output register in the next cycle
// throughput: one request per cycle unless stalled (single result register stage)
// in_stall is high only while a finished result waits and out_stall holds it
// reset (rst, synchronous): masks to pass-through, banks to reset values, irq cleared
// no clearing pass after reset; requests are taken as soon as rst is released
module bank_switch_irq_mapper_unit
  import bsim_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  req_t                   in_req,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rsp_t                   out_rsp
);

  logic [7:0]  prg_and_mask;
  logic [7:0]  prg_or_mask;
  logic [7:0]  chr_and_mask;
  logic [7:0]  chr_or_mask;
  logic        wram_always_on;

  logic [7:0]  program_bank;
  logic [7:0]  pattern_banks [PATTERN_SLOTS];
  mirror_t     mirror_mode;
  logic [15:0] cycle_counter;
  logic [15:0] reload_value;
  logic        irq_enable;
  logic        wram_enable;
  logic        irq_line;

  logic [15:0] cycle_counter_next;
  logic        irq_enable_next;
  logic        irq_line_next;
  logic [15:0] counter_dec;

  logic        accept;
  logic [3:0]  sel;
  logic [13:0] ppu_addr;
  logic [7:0]  cpu_bank;
  logic [7:0]  chr_bank;
  logic        nt_page;
  rsp_t        result;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;
  assign sel      = in_req.address[3:0];
  assign ppu_addr = in_req.address[13:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_and_mask   <= 8'hFF;
      prg_or_mask    <= 8'h00;
      chr_and_mask   <= 8'hFF;
      chr_or_mask    <= 8'h00;
      wram_always_on <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_PRG_AND:   prg_and_mask   <= cfg_data;
        CFG_PRG_OR:    prg_or_mask    <= cfg_data;
        CFG_CHR_AND:   chr_and_mask   <= cfg_data;
        CFG_CHR_OR:    chr_or_mask    <= cfg_data;
        CFG_WRAM_ALWS: wram_always_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // counter and irq next state
  always_comb begin
    counter_dec        = cycle_counter - 16'd1;
    cycle_counter_next = cycle_counter;
    irq_enable_next    = irq_enable;
    irq_line_next      = irq_line;
    case (in_req.op)
      OP_WRITE: begin
        if (sel == REG_IRQ_CTRL) begin
          irq_enable_next    = in_req.write_data[0];
          cycle_counter_next = reload_value;
          irq_line_next      = in_req.write_data[0] && (reload_value == 16'd0);
        end
      end
      OP_TICK: begin
        if (irq_enable) begin
          cycle_counter_next = counter_dec;
          // ticks only ever raise the line
          if (counter_dec == 16'd0) begin
            irq_line_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // bus register file and counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      program_bank  <= 8'd0;
      mirror_mode   <= MIRROR_VERTICAL;
      cycle_counter <= 16'd0;
      reload_value  <= 16'd0;
      irq_enable    <= 1'b0;
      wram_enable   <= 1'b0;
      irq_line      <= 1'b0;
      for (int i = 0; i < PATTERN_SLOTS; i++) begin
        pattern_banks[i] <= 8'(i);
      end
    end else if (accept) begin
      cycle_counter <= cycle_counter_next;
      irq_enable    <= irq_enable_next;
      irq_line      <= irq_line_next;
      if (in_req.op == OP_WRITE) begin
        if (!sel[3]) begin
          pattern_banks[sel[SLOT_W-1:0]] <= in_req.write_data;
        end
        case (sel)
          REG_PRG_BANK: program_bank       <= in_req.write_data;
          REG_MIRROR:   mirror_mode        <= mirror_t'(in_req.write_data[1:0]);
          REG_RELOAD_L: reload_value[7:0]  <= in_req.write_data;
          REG_RELOAD_H: reload_value[15:8] <= in_req.write_data;
          REG_WRAM_EN:  wram_enable        <= in_req.write_data[WRAM_EN_BIT];
          default: ;
        endcase
      end
    end
  end

  // address translation
  always_comb begin
    // upper cpu window is fixed to the last bank
    if (in_req.address[14]) begin
      cpu_bank = prg_and_mask | prg_or_mask;
    end else begin
      cpu_bank = (program_bank & prg_and_mask) | prg_or_mask;
    end
    chr_bank = (pattern_banks[ppu_addr[12:10]] & chr_and_mask) | chr_or_mask;
    case (mirror_mode)
      MIRROR_VERTICAL:   nt_page = ppu_addr[10];
      MIRROR_HORIZONTAL: nt_page = ppu_addr[11];
      MIRROR_SINGLE_0:   nt_page = 1'b0;
      default:           nt_page = 1'b1;
    endcase

    result.irq_active     = irq_line_next;
    result.mapped_address = '0;
    result.mapped_valid   = 1'b0;
    case (in_req.op)
      OP_CPU: begin
        if (in_req.address[15]) begin
          result.mapped_address = {cpu_bank, in_req.address[13:0]};
          result.mapped_valid   = 1'b1;
        end else if (in_req.address[14:13] == 2'b11 && (wram_enable || wram_always_on)) begin
          result.mapped_address = {9'd0, in_req.address[12:0]};
          result.mapped_valid   = 1'b1;
        end
      end
      OP_PPU: begin
        result.mapped_valid = 1'b1;
        if (!ppu_addr[13]) begin
          result.mapped_address = {4'd0, chr_bank, ppu_addr[9:0]};
        end else begin
          // nametable range, including the mirror above it
          result.mapped_address = {11'd0, nt_page, ppu_addr[9:0]};
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rsp <= result;
    end
  end

  // irq line drops only through a write to the irq control register
  assert property (@(posedge clk) disable iff (rst)
    $fell(irq_line) |-> $past(accept && in_req.op == OP_WRITE && sel == REG_IRQ_CTRL))
    else $error("irq line cleared without an irq control write");

  // a miss always carries a zero offset
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rsp.mapped_valid |-> out_rsp.mapped_address == '0)
    else $error("unmapped result with nonzero offset");

  // the counter moves only on an accepted request
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(accept) |-> $stable(cycle_counter))
    else $error("cycle counter changed without a request");

  // a disabled counter never raises the line
  assert property (@(posedge clk) disable iff (rst)
    $rose(irq_line) |-> $past(in_req.op == OP_WRITE) || $past(irq_enable))
    else $error("irq line raised by a tick while disabled");

endmodule
